// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the responder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a clocked property, disabled during reset.
`define ASSERT_PROP(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition never holds at a clock edge.
`define ASSERT_NEVER(name, clk, rst, cond, msg) \
   `ASSERT_PROP(name, clk, rst, !(cond), msg)

`endif

// ===== rtl/core/tpor_pkg.sv =====
// Package: types, constants and flag codes of the TCP passive open responder.
package tpor_pkg;

   localparam int CONN_ENTRIES_DEF = 16;

   localparam int CSR_ADDR_W = 2;
   localparam logic [CSR_ADDR_W-1:0] CSR_INIT_SEQ = '0;
   localparam logic [31:0] INIT_SEQ_RESET = 32'd200;

   localparam logic [7:0] FLAG_SYN     = 8'h02;
   localparam logic [7:0] FLAG_ACK     = 8'h10;
   localparam logic [7:0] FLAG_FIN_ACK = 8'h11;
   localparam logic [7:0] FLAG_SYN_ACK = 8'h12;

   typedef struct packed {
      logic [31:0] peer_ip;
      logic [31:0] local_ip;
      logic [15:0] peer_port;
      logic [15:0] local_port;
      logic [31:0] seq_in;
      logic [31:0] ack_in;
      logic [15:0] window_in;
      logic [7:0]  flags_in;
   } tpor_seg_type;

   typedef struct packed {
      logic [31:0] reply_src_ip;
      logic [31:0] reply_dst_ip;
      logic [15:0] reply_src_port;
      logic [15:0] reply_dst_port;
      logic [31:0] reply_seq;
      logic [31:0] reply_ack;
      logic [7:0]  reply_flags;
      logic [15:0] reply_window;
   } tpor_reply_type;

   typedef struct packed {
      logic capture;
      logic scan;
      logic commit;
   } tpor_cmd_type;

   typedef struct packed {
      logic scan_last;
      logic commit_ok;
   } tpor_sts_type;

endpackage

// ===== rtl/core/tpor_if.sv =====
// Interfaces: received segment channel and reply channel.
interface tpor_seg_if;
   logic        valid;
   logic        ready;
   logic [31:0] peer_ip;
   logic [31:0] local_ip;
   logic [15:0] peer_port;
   logic [15:0] local_port;
   logic [31:0] seq_in;
   logic [31:0] ack_in;
   logic [15:0] window_in;
   logic [7:0]  flags_in;

   modport source (
      output valid, peer_ip, local_ip, peer_port, local_port, seq_in, ack_in,
         window_in, flags_in,
      input ready
   );
   modport sink (
      input valid, peer_ip, local_ip, peer_port, local_port, seq_in, ack_in,
         window_in, flags_in,
      output ready
   );
endinterface

interface tpor_reply_if;
   logic        valid;
   logic        ready;
   logic [31:0] reply_src_ip;
   logic [31:0] reply_dst_ip;
   logic [15:0] reply_src_port;
   logic [15:0] reply_dst_port;
   logic [31:0] reply_seq;
   logic [31:0] reply_ack;
   logic [7:0]  reply_flags;
   logic [15:0] reply_window;

   modport source (
      output valid, reply_src_ip, reply_dst_ip, reply_src_port, reply_dst_port,
         reply_seq, reply_ack, reply_flags, reply_window,
      input ready
   );
   modport sink (
      input valid, reply_src_ip, reply_dst_ip, reply_src_port, reply_dst_port,
         reply_seq, reply_ack, reply_flags, reply_window,
      output ready
   );
endinterface

// ===== rtl/core/tcp_passive_open_responder.sv =====
// Top level: TCP passive open responder with connection table and APB register.
//
//   channel  dir  handshake             beat
//   req      in   valid/ready           one received segment header
//   rsp      out  valid/ready           one SYN+ACK or ACK reply
//   csr      in   APB, pready tied high initial_sequence at byte address 0
//
// A segment is taken only once the last one is committed; the table scan reads
// the entry memory through its single read port, one entry per cycle.
// Reset clears the entry valid bits and the reply valid bit; no clearing pass.
// A reply waiting on rsp does not stop the next segment; only a commit that
// produces a reply holds until the output register is free.
module tcp_passive_open_responder #(
   parameter int CONN_ENTRIES = tpor_pkg::CONN_ENTRIES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   tpor_seg_if.sink                        req,
   tpor_reply_if.source                    rsp,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [tpor_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);

   tpor_pkg::tpor_cmd_type   cmd;
   tpor_pkg::tpor_sts_type   sts;
   tpor_pkg::tpor_seg_type   seg;
   tpor_pkg::tpor_reply_type reply;
   logic                     req_ready;
   logic                     reply_valid;
   logic                     csr_wr;
   logic [31:0]              init_seq;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite
                    && (csr_paddr == tpor_pkg::CSR_INIT_SEQ);
   assign csr_prdata = (csr_paddr == tpor_pkg::CSR_INIT_SEQ) ? init_seq : 32'd0;

   assign seg = '{peer_ip: req.peer_ip, local_ip: req.local_ip,
                  peer_port: req.peer_port, local_port: req.local_port,
                  seq_in: req.seq_in, ack_in: req.ack_in,
                  window_in: req.window_in, flags_in: req.flags_in};
   assign req.ready = req_ready;

   assign rsp.valid          = reply_valid;
   assign rsp.reply_src_ip   = reply.reply_src_ip;
   assign rsp.reply_dst_ip   = reply.reply_dst_ip;
   assign rsp.reply_src_port = reply.reply_src_port;
   assign rsp.reply_dst_port = reply.reply_dst_port;
   assign rsp.reply_seq      = reply.reply_seq;
   assign rsp.reply_ack      = reply.reply_ack;
   assign rsp.reply_flags    = reply.reply_flags;
   assign rsp.reply_window   = reply.reply_window;

   tpor_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   tpor_dp #(
      .CONN_ENTRIES (CONN_ENTRIES)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .seg         (seg),
      .csr_wr      (csr_wr),
      .csr_wdata   (csr_pwdata),
      .init_seq    (init_seq),
      .reply       (reply),
      .reply_valid (reply_valid),
      .reply_ready (rsp.ready)
   );

endmodule

// ===== rtl/core/tpor_ctrl.sv =====
// Controller: sequences capture, table scan and commit of one segment.
`include "assert_macros.svh"

module tpor_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output tpor_pkg::tpor_cmd_type cmd,
   input  tpor_pkg::tpor_sts_type sts
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_DRAIN  = 2'd2;
   localparam logic [1:0] ST_COMMIT = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      cmd         = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (sts.commit_ok) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `ASSERT_PROP(a_capture_starts_scan, clock, reset, cmd.capture |=> state_ff == ST_SCAN, "capture did not start scan")
   `ASSERT_PROP(a_last_scan_drains, clock, reset, (state_ff == ST_SCAN && sts.scan_last) |=> state_ff == ST_DRAIN, "scan overran table")

endmodule

// ===== rtl/core/tpor_dp.sv =====
// Datapath: segment register, connection table, lookup and reply register.
`include "assert_macros.svh"

module tpor_dp #(
   parameter int CONN_ENTRIES = tpor_pkg::CONN_ENTRIES_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  tpor_pkg::tpor_cmd_type   cmd,
   output tpor_pkg::tpor_sts_type   sts,
   input  tpor_pkg::tpor_seg_type   seg,
   input  logic                     csr_wr,
   input  logic [31:0]              csr_wdata,
   output logic [31:0]              init_seq,
   output tpor_pkg::tpor_reply_type reply,
   output logic                     reply_valid,
   input  logic                     reply_ready
);

   localparam int IW = (CONN_ENTRIES > 1) ? $clog2(CONN_ENTRIES) : 1;

   typedef struct packed {
      logic        established;
      logic [31:0] peer_ip;
      logic [15:0] peer_port;
   } entry_type;

   tpor_pkg::tpor_seg_type   seg_ff;
   tpor_pkg::tpor_reply_type reply_ff;
   logic [31:0]              init_seq_ff;
   logic [31:0]              init_seq_in;
   logic [CONN_ENTRIES-1:0]  valid_ff;
   logic [CONN_ENTRIES-1:0]  valid_in;
   entry_type                entry_mem [CONN_ENTRIES];
   entry_type                rd_entry_ff;
   logic [IW-1:0]            scan_idx_ff;
   logic [IW-1:0]            scan_idx_in;
   logic [IW-1:0]            cmp_idx_ff;
   logic                     cmp_vld_ff;
   logic                     hit_ff;
   logic                     hit_in;
   logic [IW-1:0]            hit_idx_ff;
   logic [IW-1:0]            hit_idx_in;
   logic                     hit_est_ff;
   logic                     hit_est_in;
   logic                     free_ff;
   logic                     free_in;
   logic [IW-1:0]            free_idx_ff;
   logic [IW-1:0]            free_idx_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;

   logic      entry_hit;
   logic      entry_free;
   logic      is_syn;
   logic      is_ack;
   logic      is_fin_ack;
   logic      new_conn;
   logic      establish;
   logic      close_conn;
   logic      do_reply;
   logic      mem_we;
   logic [IW-1:0] wr_idx;
   entry_type wr_entry;
   tpor_pkg::tpor_reply_type reply_in;

   assign entry_hit  = cmp_vld_ff && valid_ff[cmp_idx_ff]
                    && (rd_entry_ff.peer_ip == seg_ff.peer_ip)
                    && (rd_entry_ff.peer_port == seg_ff.peer_port);
   assign entry_free = cmp_vld_ff && !valid_ff[cmp_idx_ff];

   assign is_syn     = (seg_ff.flags_in == tpor_pkg::FLAG_SYN);
   assign is_ack     = (seg_ff.flags_in == tpor_pkg::FLAG_ACK);
   assign is_fin_ack = (seg_ff.flags_in == tpor_pkg::FLAG_FIN_ACK);

   assign new_conn   = !hit_ff && is_syn && free_ff;
   assign establish  = hit_ff && !hit_est_ff && is_ack;
   assign close_conn = hit_ff && hit_est_ff && is_fin_ack;
   assign do_reply   = new_conn || close_conn;

   assign mem_we   = cmd.commit && (new_conn || establish);
   assign wr_idx   = new_conn ? free_idx_ff : hit_idx_ff;
   assign wr_entry = '{established: establish, peer_ip: seg_ff.peer_ip,
                       peer_port: seg_ff.peer_port};

   assign sts.scan_last = (scan_idx_ff == IW'(CONN_ENTRIES - 1));
   assign sts.commit_ok = !do_reply || !rsp_valid_ff || reply_ready;

   always_comb begin
      reply_in.reply_src_ip   = seg_ff.local_ip;
      reply_in.reply_dst_ip   = seg_ff.peer_ip;
      reply_in.reply_src_port = seg_ff.local_port;
      reply_in.reply_dst_port = seg_ff.peer_port;
      reply_in.reply_seq      = close_conn ? seg_ff.ack_in : init_seq_ff;
      reply_in.reply_ack      = seg_ff.seq_in + 32'd1;
      reply_in.reply_flags    = new_conn ? tpor_pkg::FLAG_SYN_ACK : tpor_pkg::FLAG_ACK;
      reply_in.reply_window   = seg_ff.window_in;
   end

   always_comb begin
      init_seq_in  = csr_wr ? csr_wdata : init_seq_ff;
      scan_idx_in  = scan_idx_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      hit_est_in   = hit_est_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      valid_in     = valid_ff;
      rsp_valid_in = rsp_valid_ff;
      if (cmd.capture) begin
         scan_idx_in = '0;
         hit_in      = 1'b0;
         free_in     = 1'b0;
      end
      if (cmd.scan) begin
         scan_idx_in = scan_idx_ff + 1'b1;
      end
      if (entry_hit && !hit_ff) begin
         hit_in     = 1'b1;
         hit_idx_in = cmp_idx_ff;
         hit_est_in = rd_entry_ff.established;
      end
      if (entry_free && !free_ff) begin
         free_in     = 1'b1;
         free_idx_in = cmp_idx_ff;
      end
      if (reply_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.commit) begin
         if (new_conn) begin
            valid_in[free_idx_ff] = 1'b1;
         end
         if (close_conn) begin
            valid_in[hit_idx_ff] = 1'b0;
         end
         if (do_reply) begin
            rsp_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_seq_ff  <= tpor_pkg::INIT_SEQ_RESET;
         valid_ff     <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         init_seq_ff  <= init_seq_in;
         valid_ff     <= valid_in;
         cmp_vld_ff   <= cmd.scan;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_idx_ff <= scan_idx_in;
      cmp_idx_ff  <= scan_idx_ff;
      hit_ff      <= hit_in;
      hit_idx_ff  <= hit_idx_in;
      hit_est_ff  <= hit_est_in;
      free_ff     <= free_in;
      free_idx_ff <= free_idx_in;
      if (cmd.capture) begin
         seg_ff <= seg;
      end
      if (cmd.commit && do_reply) begin
         reply_ff <= reply_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[wr_idx] <= wr_entry;
      end
      if (cmd.scan) begin
         rd_entry_ff <= entry_mem[scan_idx_ff];
      end
   end

   assign init_seq    = init_seq_ff;
   assign reply       = reply_ff;
   assign reply_valid = rsp_valid_ff;

   `ASSERT_PROP(a_reply_after_commit, clock, reset, (cmd.commit && do_reply) |=> rsp_valid_ff, "reply beat lost")
   `ASSERT_PROP(a_new_entry_valid, clock, reset, (cmd.commit && new_conn) |=> valid_ff[free_idx_ff], "new entry not marked valid")
   `ASSERT_NEVER(a_no_overwrite, clock, reset, cmd.commit && do_reply && rsp_valid_ff && !reply_ready, "reply overwrote held beat")

endmodule
